>>> hw/rtl/color_gradient_table_assert.svh
// Assertion macros shared by the RTL.
`ifndef COLOR_GRADIENT_TABLE_ASSERT_SVH
`define COLOR_GRADIENT_TABLE_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define CGT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define CGT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/cgt_pkg.sv
package cgt_pkg;

  localparam int ENTRIES_DEF = 10;

  localparam int POS_W   = 17;
  localparam int COLOR_W = 32;
  localparam int ACC_W   = 25;

  localparam logic [POS_W-1:0] POS_ONE = 17'd65536;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_LOOKUP_DONE = 3'd0,
    ST_INSERTED    = 3'd1,
    ST_FULL        = 3'd2,
    ST_CLEARED     = 3'd3,
    ST_EMPTY       = 3'd4
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] color;
  } stop_t;

endpackage

>>> hw/rtl/color_gradient_table.sv
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | in_operation, in_position, in_red/green/blue/alpha_in
// out     | out_valid / out_ready  | out_red/green/blue/alpha, out_status, out_stop_count
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Clear, full insert and empty lookup go straight to the output handshake.
// Insert: scan the stops for the slot, shift the later stops up one place, write the new stop.
// Lookup: scan for the bracketing pair, then 2 multiplies + 8 divide steps per channel.
// rst_n (synchronous) empties the table; stop memory contents are not cleared.
// A result held on out_valid blocks the next request until out_ready.
module color_gradient_table
  import cgt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic signed [17:0] in_position,
  input  logic [7:0]         in_red_in,
  input  logic [7:0]         in_green_in,
  input  logic [7:0]         in_blue_in,
  input  logic [7:0]         in_alpha_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic [2:0]         out_status,
  output logic [3:0]         out_stop_count
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_SCAN_RD, S_INS_SCAN_CMP, S_INS_SHIFT_RD, S_INS_SHIFT_WR, S_INS_WR,
    S_LK_RD0, S_LK_CMP0, S_LK_CMPL, S_LK_SCAN_RD, S_LK_SCAN_CMP,
    S_MUL0, S_MUL1, S_DIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic signed [17:0]  pos_r, pos_nxt;
  logic [COLOR_W-1:0]  cin_r, cin_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       slot_r, slot_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  stop_t               lo_r, lo_nxt;
  stop_t               hi_r, hi_nxt;
  logic [POS_W-1:0]    d0_r, d0_nxt, d1_r, d1_nxt, span_r, span_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [7:0]          q_r, q_nxt;
  logic [2:0]          bit_r, bit_nxt;
  logic [1:0]          ch_r, ch_nxt;
  logic [COLOR_W-1:0]  res_r, res_nxt;
  status_t             status_r, status_nxt;
  logic                ovalid_r, ovalid_nxt;

  // table memory
  stop_t               mem [ENTRIES];
  stop_t               rdata_r;
  logic [AW-1:0]       raddr;
  logic                we;
  logic [AW-1:0]       waddr;
  stop_t               wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  logic [CW-1:0]       last;
  logic signed [17:0]  rpos_s;
  logic [7:0]          mul_a;
  logic [POS_W-1:0]    mul_b;
  logic [ACC_W-1:0]    prod;
  logic [ACC_W-1:0]    sub_val;
  logic [7:0]          q_bit;

  assign last    = count_r - 1'b1;
  assign rpos_s  = $signed({1'b0, rdata_r.pos});
  assign prod    = ACC_W'(mul_a) * ACC_W'(mul_b);
  assign sub_val = ACC_W'(span_r) << bit_r;
  assign q_bit   = 8'd1 << bit_r;

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    cin_nxt    = cin_r;
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    d0_nxt     = d0_r;
    d1_nxt     = d1_r;
    span_nxt   = span_r;
    acc_nxt    = acc_r;
    q_nxt      = q_r;
    bit_nxt    = bit_r;
    ch_nxt     = ch_r;
    res_nxt    = res_r;
    status_nxt = status_r;
    ovalid_nxt = ovalid_r;
    raddr      = idx_r[AW-1:0];
    we         = 1'b0;
    waddr      = idx_r[AW-1:0];
    wdata      = rdata_r;
    mul_a      = lo_r.color[ch_r*8 +: 8];
    mul_b      = d1_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt = in_position;
          cin_nxt = {in_alpha_in, in_blue_in, in_green_in, in_red_in};
          res_nxt = '0;
          idx_nxt = '0;
          case (op_t'(in_operation))
            OP_CLEAR: begin
              count_nxt  = '0;
              status_nxt = ST_CLEARED;
              state_nxt  = S_OUT;
            end
            OP_INSERT: begin
              if (count_r >= FULL_CNT) begin
                status_nxt = ST_FULL;
                state_nxt  = S_OUT;
              end else begin
                // clamp to [0, 1.0]
                if (in_position < 0) begin
                  pos_nxt = '0;
                end else if (in_position > $signed({1'b0, POS_ONE})) begin
                  pos_nxt = $signed({1'b0, POS_ONE});
                end
                state_nxt = S_INS_SCAN_RD;
              end
            end
            OP_LOOKUP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_OUT;
              end else begin
                state_nxt = S_LK_RD0;
              end
            end
            default: state_nxt = S_IDLE; // unused code: drop
          endcase
          if (op_t'(in_operation) != OP_NONE && state_nxt == S_OUT) begin
            ovalid_nxt = 1'b1;
          end
        end
      end

      S_INS_SCAN_RD: begin
        if (idx_r == count_r) begin
          slot_nxt  = count_r;
          idx_nxt   = count_r;
          state_nxt = S_INS_SHIFT_RD;
        end else begin
          state_nxt = S_INS_SCAN_CMP;
        end
      end

      S_INS_SCAN_CMP: begin
        if (pos_r[POS_W-1:0] < rdata_r.pos) begin
          slot_nxt  = idx_r;
          idx_nxt   = count_r;
          state_nxt = S_INS_SHIFT_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_INS_SCAN_RD;
        end
      end

      S_INS_SHIFT_RD: begin
        raddr = AW'(idx_r - 1'b1);
        if (idx_r == slot_r) begin
          state_nxt = S_INS_WR;
        end else begin
          state_nxt = S_INS_SHIFT_WR;
        end
      end

      S_INS_SHIFT_WR: begin
        we        = 1'b1;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_INS_SHIFT_RD;
      end

      S_INS_WR: begin
        we         = 1'b1;
        waddr      = slot_r[AW-1:0];
        wdata      = '{pos: pos_r[POS_W-1:0], color: cin_r};
        count_nxt  = count_r + 1'b1;
        status_nxt = ST_INSERTED;
        ovalid_nxt = 1'b1;
        state_nxt  = S_OUT;
      end

      S_LK_RD0: begin
        raddr     = '0;
        state_nxt = S_LK_CMP0;
      end

      S_LK_CMP0: begin
        lo_nxt = rdata_r;
        raddr  = last[AW-1:0];
        if (pos_r <= rpos_s) begin
          res_nxt    = rdata_r.color;
          status_nxt = ST_LOOKUP_DONE;
          ovalid_nxt = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_LK_CMPL;
        end
      end

      S_LK_CMPL: begin
        if (pos_r >= rpos_s) begin
          res_nxt    = rdata_r.color;
          status_nxt = ST_LOOKUP_DONE;
          ovalid_nxt = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          idx_nxt   = CW'(1);
          state_nxt = S_LK_SCAN_RD;
        end
      end

      S_LK_SCAN_RD: begin
        state_nxt = S_LK_SCAN_CMP;
      end

      S_LK_SCAN_CMP: begin
        if (idx_r < last && pos_r > rpos_s) begin
          lo_nxt    = rdata_r;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_LK_SCAN_RD;
        end else begin
          // bracketing pair found: lo_r below, this entry above
          hi_nxt    = rdata_r;
          d1_nxt    = rdata_r.pos - pos_r[POS_W-1:0];
          d0_nxt    = pos_r[POS_W-1:0] - lo_r.pos;
          span_nxt  = rdata_r.pos - lo_r.pos;
          ch_nxt    = '0;
          state_nxt = S_MUL0;
        end
      end

      S_MUL0: begin
        acc_nxt   = prod;
        state_nxt = S_MUL1;
      end

      S_MUL1: begin
        mul_a     = hi_r.color[ch_r*8 +: 8];
        mul_b     = d0_r;
        acc_nxt   = acc_r + prod;
        q_nxt     = '0;
        bit_nxt   = 3'd7;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        if (acc_r >= sub_val) begin
          acc_nxt = acc_r - sub_val;
          q_nxt   = q_r | q_bit;
        end
        bit_nxt = bit_r - 1'b1;
        if (bit_r == 3'd0) begin
          res_nxt[ch_r*8 +: 8] = (acc_r >= sub_val) ? (q_r | q_bit) : q_r;
          ch_nxt = ch_r + 1'b1;
          if (ch_r == 2'd3) begin
            status_nxt = ST_LOOKUP_DONE;
            ovalid_nxt = 1'b1;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_MUL0;
          end
        end
      end

      S_OUT: begin
        if (out_ready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
    pos_r    <= pos_nxt;
    cin_r    <= cin_nxt;
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    d0_r     <= d0_nxt;
    d1_r     <= d1_nxt;
    span_r   <= span_nxt;
    acc_r    <= acc_nxt;
    q_r      <= q_nxt;
    bit_r    <= bit_nxt;
    ch_r     <= ch_nxt;
    res_r    <= res_nxt;
    status_r <= status_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = ovalid_r;
  assign out_red        = res_r[7:0];
  assign out_green      = res_r[15:8];
  assign out_blue       = res_r[23:16];
  assign out_alpha      = res_r[31:24];
  assign out_status     = status_r;
  assign out_stop_count = 4'(count_r);

`include "color_gradient_table_assert.svh"

  `CGT_ASSERT_ALWAYS(a_count_bound, count_r <= FULL_CNT)
  `CGT_ASSERT_IMP(a_one_request, in_ready, !out_valid)
  `CGT_ASSERT_IMP(a_div_span, state_r == S_DIV, span_r != '0)
  `CGT_ASSERT_IMP(a_zero_color, out_valid && out_status != ST_LOOKUP_DONE, res_r == '0)

endmodule
